// File: rtl/rpds_pkg.sv
// shared types, constants and the popcount helper of the row profile score block
// no dependencies
package rpds_pkg;

  localparam int unsigned REG_W     = 14;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SCORE_W   = 39;
  localparam int unsigned TDATA_O_W = 40;
  localparam int unsigned LANE_SH   = 5;
  localparam int unsigned POP_W     = 6;

  localparam logic [LANE_SH-1:0] LANE_LAST = 5'd31;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic first_row;
    logic last_row;
  } row_flags_t;

  function automatic logic [POP_W-1:0] count_ones(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/rpds_row_count.sv
// input register, masked popcount and per-row black pixel count
// depends on rpds_pkg
module rpds_row_count
  import rpds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 8192,
  parameter int unsigned MAX_HEIGHT = 8192,
  parameter int unsigned CNT_W      = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [WORD_W-1:0] in_word_i,
  input  logic [REG_W-1:0]  width_i,
  input  logic [REG_W-1:0]  height_i,
  output logic              row_valid_o,
  output logic [CNT_W-1:0]  row_count_o,
  output row_flags_t        row_flags_o
);

  localparam int unsigned LW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW     = (LW_RAW > REG_W) ? LW_RAW : REG_W;
  localparam int unsigned LH_RAW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LH     = (LH_RAW > REG_W) ? LH_RAW : REG_W;
  localparam int unsigned WP_RAW = $clog2((MAX_WIDTH + 31) / 32);
  localparam int unsigned WP_W   = (WP_RAW > 1) ? WP_RAW : 1;
  localparam int unsigned RP_W   = $clog2(MAX_HEIGHT);

  logic              in_valid_q;
  logic [WORD_W-1:0] in_word_q;
  logic [WP_W-1:0]   word_pos_q, word_pos_d;
  logic [RP_W-1:0]   row_pos_q, row_pos_d;
  logic [CNT_W-1:0]  row_cnt_q, row_cnt_d;
  logic              row_valid_q;
  logic [CNT_W-1:0]  row_count_q;
  row_flags_t        row_flags_q;

  logic [LW-1:0]      w_ext, w_eff, w_m1, last_word;
  logic [LH-1:0]      h_ext, h_eff;
  logic [LANE_SH-1:0] shift;
  logic [WORD_W-1:0]  mask, sel_mask;
  logic               last_word_now, last_row_now;
  logic [CNT_W-1:0]   count_sum;

  always_comb begin
    w_ext = LW'(width_i);
    h_ext = LH'(height_i);
    priority if (width_i == '0) begin
      w_eff = LW'(1);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    priority if (height_i == '0) begin
      h_eff = LH'(1);
    end else if (h_ext > LH'(MAX_HEIGHT)) begin
      h_eff = LH'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_m1          = w_eff - LW'(1);
    last_word     = w_m1 >> LANE_SH;
    shift         = LANE_LAST - w_m1[LANE_SH-1:0];
    mask          = {WORD_W{1'b1}} << shift;
    last_word_now = LW'(word_pos_q) >= last_word;
    last_row_now  = LH'(row_pos_q) >= (h_eff - LH'(1));
    sel_mask      = last_word_now ? mask : {WORD_W{1'b1}};
    count_sum     = row_cnt_q + CNT_W'(count_ones(in_word_q & sel_mask));
  end

  always_comb begin
    word_pos_d = word_pos_q;
    row_pos_d  = row_pos_q;
    row_cnt_d  = row_cnt_q;
    if (en_i && in_valid_q) begin
      if (last_word_now) begin
        word_pos_d = '0;
        row_cnt_d  = '0;
        row_pos_d  = last_row_now ? '0 : row_pos_q + RP_W'(1);
      end else begin
        word_pos_d = word_pos_q + WP_W'(1);
        row_cnt_d  = count_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      row_valid_q <= 1'b0;
      word_pos_q  <= '0;
      row_pos_q   <= '0;
      row_cnt_q   <= '0;
    end else begin
      word_pos_q <= word_pos_d;
      row_pos_q  <= row_pos_d;
      row_cnt_q  <= row_cnt_d;
      if (en_i) begin
        in_valid_q  <= in_valid_i;
        row_valid_q <= in_valid_q && last_word_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      in_word_q <= in_word_i;
    end
    if (en_i && in_valid_q && last_word_now) begin
      row_count_q           <= count_sum;
      row_flags_q.first_row <= (row_pos_q == '0);
      row_flags_q.last_row  <= last_row_now;
    end
  end

  assign row_valid_o = row_valid_q;
  assign row_count_o = row_count_q;
  assign row_flags_o = row_flags_q;

endmodule

// File: rtl/rpds_diff_sq.sv
// row-to-row count difference and its square
// depends on rpds_pkg
module rpds_diff_sq
  import rpds_pkg::*;
#(
  parameter int unsigned CNT_W = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               row_valid_i,
  input  logic [CNT_W-1:0]   row_count_i,
  input  row_flags_t         row_flags_i,
  output logic               sq_valid_o,
  output logic [2*CNT_W-1:0] sq_o,
  output row_flags_t         sq_flags_o
);

  logic [CNT_W-1:0]   prev_q, prev_d;
  logic               sq_valid_q;
  logic [2*CNT_W-1:0] sq_q;
  row_flags_t         sq_flags_q;
  logic [CNT_W-1:0]   diff;

  always_comb begin
    diff   = (row_count_i >= prev_q) ? (row_count_i - prev_q) : (prev_q - row_count_i);
    prev_d = prev_q;
    if (en_i && row_valid_i) begin
      prev_d = row_flags_i.last_row ? '0 : row_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      sq_valid_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      if (en_i) begin
        sq_valid_q <= row_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && row_valid_i) begin
      sq_q       <= (2*CNT_W)'(diff) * (2*CNT_W)'(diff);
      sq_flags_q <= row_flags_i;
    end
  end

  assign sq_valid_o = sq_valid_q;
  assign sq_o       = sq_q;
  assign sq_flags_o = sq_flags_q;

endmodule

// File: rtl/rpds_score_acc.sv
// saturating score accumulator and result register
// depends on rpds_pkg
module rpds_score_acc
  import rpds_pkg::*;
#(
  parameter int unsigned SQ_W = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               sq_valid_i,
  input  logic [SQ_W-1:0]    sq_i,
  input  row_flags_t         sq_flags_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [SCORE_W-1:0] score_o
);

  logic [SCORE_W-1:0] score_q, score_d;
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] out_score_q;
  logic [SCORE_W:0]   sum;
  logic [SCORE_W-1:0] sat;
  logic               take;

  always_comb begin
    take = en_i && sq_valid_i;
    sum  = {1'b0, score_q} + (sq_flags_i.first_row ? '0 : (SCORE_W+1)'(sq_i));
    sat  = (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[SCORE_W-1:0];
    score_d     = score_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      score_d = sq_flags_i.last_row ? '0 : sat;
      if (sq_flags_i.last_row) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      score_q     <= score_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && sq_flags_i.last_row) begin
      out_score_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;

endmodule

// File: rtl/row_profile_difference_score_top.sv
// top level of the row profile difference score block
// depends on rpds_pkg, rpds_row_count, rpds_diff_sq and rpds_score_acc
//
// channel  direction  handshake               payload
// s_axis   in         tvalid / tready         tdata[31:0] = pixel_word
// m_axis   out        tvalid / tready         tdata[38:0] = score, bit 39 zero
// cfg      in         cfg_valid / cfg_ready   cfg_index (0 width, 1 height), cfg_data
//
// one item per cycle while s_axis_tready is high; the score of an image passes
// through the input, row count and square stages into the result register
// reset sets width and height to 8192 and clears all counters and the running score
// s_axis_tready drops only while a finished score waits in the result register
// and the next image's score is ready to enter it
module row_profile_difference_score_top
  import rpds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 8192,
  parameter int unsigned MAX_HEIGHT = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_W-1:0]    s_axis_tdata,   // pixel_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_O_W-1:0] m_axis_tdata,   // score, zero pad
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cfg_idx_t             cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(32 * ((MAX_WIDTH + 31) / 32) + 1);
  localparam int unsigned SQ_W  = 2 * CNT_W;

  logic [REG_W-1:0]   width_q, height_q;
  logic               en;
  logic               row_valid;
  logic [CNT_W-1:0]   row_count;
  row_flags_t         row_flags;
  logic               sq_valid;
  logic [SQ_W-1:0]    sq;
  row_flags_t         sq_flags;
  logic [SCORE_W-1:0] score;
  logic               score_ends;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_W'(8192);
      height_q <= REG_W'(8192);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign score_ends    = sq_valid && sq_flags.last_row;
  assign en            = !(m_axis_tvalid && !m_axis_tready && score_ends);
  assign s_axis_tready = en;
  assign m_axis_tdata  = TDATA_O_W'(score);

  rpds_row_count #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CNT_W      (CNT_W)
  ) u_row_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .in_word_i   (s_axis_tdata),
    .width_i     (width_q),
    .height_i    (height_q),
    .row_valid_o (row_valid),
    .row_count_o (row_count),
    .row_flags_o (row_flags)
  );

  rpds_diff_sq #(
    .CNT_W (CNT_W)
  ) u_diff_sq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .row_valid_i (row_valid),
    .row_count_i (row_count),
    .row_flags_i (row_flags),
    .sq_valid_o  (sq_valid),
    .sq_o        (sq),
    .sq_flags_o  (sq_flags)
  );

  rpds_score_acc #(
    .SQ_W (SQ_W)
  ) u_score_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .sq_valid_i  (sq_valid),
    .sq_i        (sq),
    .sq_flags_i  (sq_flags),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .score_o     (score)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && score_ends))
    else $error("input stalled without a blocked score");

  a_image_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (score_ends && en) |=> m_axis_tvalid)
    else $error("image end did not load the result register");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !(score_ends && en)) |=> !m_axis_tvalid)
    else $error("score presented twice");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_O_W-1] == 1'b0))
    else $error("score pad bit set");
`endif

endmodule
